// ----- rtl/core/rfdaf_pkg.sv -----
// Package for the radio frame descrambler with own-address filter.
// Holds the field widths and the descrambling constants.
// No dependencies.
`timescale 1ns / 1ps

package rfdaf_pkg;

    localparam int BYTE_W = 8;
    localparam int ADDR_W = 24;

    // Scrambler constants
    localparam logic [BYTE_W-1:0] SCRAMBLE_XOR = 8'h89;
    localparam logic [BYTE_W-1:0] CHAIN_ADD    = 8'hDC;

    // Frame positions with a special meaning
    localparam logic [BYTE_W-1:0] POS_LENGTH   = 8'd0;
    localparam logic [BYTE_W-1:0] POS_INVERT   = 8'd1;
    localparam logic [BYTE_W-1:0] POS_KEY      = 8'd2;
    localparam logic [BYTE_W-1:0] POS_ADDR_HI  = 8'd7;
    localparam logic [BYTE_W-1:0] POS_ADDR_MID = 8'd8;
    localparam logic [BYTE_W-1:0] POS_ADDR_LO  = 8'd9;
    localparam logic [BYTE_W-1:0] MIN_ADDR_LEN = 8'd8;

    typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ----- rtl/core/radio_frame_descrambler_addr_filter_top.sv -----
// Radio frame descrambler with own-address filter, top level.
// Depends on rfdaf_pkg.
`timescale 1ns / 1ps

// Usage:
//   Scrambled frame bytes enter on the s_axis channel, one word per byte;
//   s_axis_tuser set marks the length byte that opens a new frame and
//   drops any frame in progress. Each accepted word yields exactly one
//   result word on m_axis: the decoded byte and its position in the frame,
//   tlast on the final byte, and tuser on the final byte when the length
//   byte is at least eight and bytes 7 to 9, where they precede the final
//   byte, match device_address. A byte that arrives without tuser while
//   no frame is open gives an all-zero result word.
//   The input register takes each accepted word; the result register
//   takes its result from the add/xor logic between the two registers.
//   Throughput: one word per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more word if it is empty; then s_axis_tready drops.
//   Reset empties both pipeline stages and resets the frame state;
//   the address goes to zero. Write cfg_wdata with cfg_we only while idle.
module radio_frame_descrambler_addr_filter_top
    import rfdaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [ADDR_W-1:0] cfg_wdata,        // device_address
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,     // [7:0] raw_byte
    input  logic              s_axis_tuser,     // frame_start
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,     // [7:0] decoded_byte, [15:8] byte_index
    output logic              m_axis_tlast,     // last_byte
    output logic              m_axis_tuser      // for_us
);

    // Configuration
    logic [ADDR_W-1:0] device_address_reg;

    // Input register
    logic  in_vld_reg;
    byte_t in_raw_reg;
    logic  in_start_reg;

    // Result register
    logic  out_vld_reg;
    byte_t out_dec_reg;
    byte_t out_idx_reg;
    logic  out_last_reg;
    logic  out_us_reg;

    // Frame state
    byte_t position_reg, position_next;
    byte_t frame_length_reg, frame_length_next;
    byte_t previous_raw_reg, previous_raw_next;
    byte_t final_key_reg, final_key_next;
    logic  address_ok_reg, address_ok_next;
    logic  address_checked_reg, address_checked_next;

    // Combinational result
    byte_t res_dec;
    byte_t res_idx;
    logic  res_last;
    logic  res_us;
    byte_t chain_dec;
    byte_t want_byte;

    logic out_free;
    logic advance;

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign advance       = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;

    assign chain_dec = byte_t'(previous_raw_reg + CHAIN_ADD) ^ in_raw_reg;

    always_comb
    begin
        case (position_reg)
            POS_ADDR_HI:  want_byte = device_address_reg[23:16];
            POS_ADDR_MID: want_byte = device_address_reg[15:8];
            default:      want_byte = device_address_reg[7:0];
        endcase
    end

    always_comb
    begin
        res_dec              = '0;
        res_idx              = '0;
        res_last             = 1'b0;
        res_us               = 1'b0;
        position_next        = position_reg;
        frame_length_next    = frame_length_reg;
        previous_raw_next    = previous_raw_reg;
        final_key_next       = final_key_reg;
        address_ok_next      = address_ok_reg;
        address_checked_next = address_checked_reg;

        if (in_start_reg)
        begin
            // Length byte: restart the frame
            frame_length_next    = in_raw_reg;
            previous_raw_next    = in_raw_reg;
            final_key_next       = '0;
            address_ok_next      = 1'b1;
            address_checked_next = 1'b0;
            res_dec              = in_raw_reg;
            res_idx              = POS_LENGTH;
            res_last             = (in_raw_reg == '0);
            position_next        = (in_raw_reg == '0) ? POS_LENGTH : POS_INVERT;
        end
        else if (position_reg != POS_LENGTH)
        begin
            res_idx           = position_reg;
            previous_raw_next = in_raw_reg;
            if (position_reg == frame_length_reg)
            begin
                res_dec       = in_raw_reg ^ final_key_reg;
                res_last      = 1'b1;
                res_us        = (frame_length_reg >= MIN_ADDR_LEN) && address_ok_reg
                                && address_checked_reg;
                position_next = POS_LENGTH;
            end
            else
            begin
                if (position_reg == POS_INVERT)
                begin
                    res_dec = ~in_raw_reg ^ SCRAMBLE_XOR;
                end
                else
                begin
                    res_dec = chain_dec;
                    if (position_reg == POS_KEY)
                    begin
                        final_key_next = chain_dec;
                    end
                    if (position_reg >= POS_ADDR_HI && position_reg <= POS_ADDR_LO)
                    begin
                        address_checked_next = 1'b1;
                        if (chain_dec != want_byte)
                        begin
                            address_ok_next = 1'b0;
                        end
                    end
                end
                position_next = position_reg + 8'd1;
            end
        end
        // else: idle byte, drop it with an all-zero result
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= '0;
        end
        else if (cfg_we)
        begin
            device_address_reg <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_raw_reg   <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
        end
    end

    // Result register and frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg         <= 1'b0;
            position_reg        <= '0;
            frame_length_reg    <= '0;
            previous_raw_reg    <= '0;
            final_key_reg       <= '0;
            address_ok_reg      <= 1'b1;
            address_checked_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (advance)
            begin
                position_reg        <= position_next;
                frame_length_reg    <= frame_length_next;
                previous_raw_reg    <= previous_raw_next;
                final_key_reg       <= final_key_next;
                address_ok_reg      <= address_ok_next;
                address_checked_reg <= address_checked_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_dec_reg  <= res_dec;
            out_idx_reg  <= res_idx;
            out_last_reg <= res_last;
            out_us_reg   <= res_us;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_idx_reg, out_dec_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_us_reg;

`ifndef NO_ASSERTIONS
    a_us_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("for_us set on a non-final byte");

    a_us_long_frame: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> out_idx_reg >= MIN_ADDR_LEN)
        else $error("for_us set on a frame shorter than the address field");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_last |=> position_reg == POS_LENGTH)
        else $error("frame still open after its final byte");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= frame_length_reg)
        else $error("position beyond frame length");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for radio_frame_descrambler_addr_filter_top.
// Scrambles frames in the bench, predicts every result word and checks the output.
// Depends on rfdaf_pkg and the top level RTL.
`timescale 1ns / 1ps

module testbench;
    import rfdaf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int FULL_FRAME  = 256;

    typedef struct packed {
        byte_t raw;
        logic  start;
    } rx_word_t;

    typedef struct packed {
        byte_t plain;
        byte_t index;
        logic  last;
        logic  for_us;
    } plain_word_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [ADDR_W-1:0] cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;     // [7:0] raw_byte
    logic              s_axis_tuser = 1'b0;   // frame_start
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;          // [7:0] decoded_byte, [15:8] byte_index
    logic              m_axis_tlast;          // last_byte
    logic              m_axis_tuser;          // for_us

    // Descrambler state as the bench sees it
    logic [ADDR_W-1:0] own_addr = '0;
    byte_t             frame_pos = '0;
    byte_t             frame_len = '0;
    byte_t             prev_raw = '0;
    byte_t             key_byte = '0;
    logic              addr_match = 1'b1;
    logic              addr_seen = 1'b0;

    rx_word_t    raw_words[$];
    plain_word_t plain_due[$];
    rx_word_t    offered;

    logic hold_send = 1'b0;
    logic no_gaps = 1'b0;
    int   items_sent = 0;
    int   words_in = 0;
    int   words_out = 0;
    int   frames_in = 0;
    int   hits_seen = 0;
    int   long_frames = 0;
    int   mismatches = 0;
    int   quiet = 0;

    radio_frame_descrambler_addr_filter_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    function automatic plain_word_t descramble_word(rx_word_t w);
        plain_word_t r;
        byte_t       want;
        r = '0;
        if (w.start)
        begin
            frame_len  = w.raw;
            prev_raw   = w.raw;
            key_byte   = '0;
            addr_match = 1'b1;
            addr_seen  = 1'b0;
            r.plain    = w.raw;
            r.last     = (w.raw == 0);
            frame_pos  = (w.raw == 0) ? 8'd0 : 8'd1;
        end
        else if (frame_pos != 0)
        begin
            r.index = frame_pos;
            if (frame_pos == frame_len)
            begin
                r.plain   = w.raw ^ key_byte;
                r.last    = 1'b1;
                r.for_us  = (frame_len >= MIN_ADDR_LEN) && addr_match && addr_seen;
                frame_pos = '0;
            end
            else
            begin
                if (frame_pos == POS_INVERT)
                begin
                    r.plain = ~w.raw ^ SCRAMBLE_XOR;
                end
                else
                begin
                    r.plain = byte_t'(prev_raw + CHAIN_ADD) ^ w.raw;
                    if (frame_pos == POS_KEY)
                        key_byte = r.plain;
                    if (frame_pos >= POS_ADDR_HI && frame_pos <= POS_ADDR_LO)
                    begin
                        want = own_addr[(POS_ADDR_LO - frame_pos) * 8 +: 8];
                        addr_seen = 1'b1;
                        if (r.plain != want)
                            addr_match = 1'b0;
                    end
                end
                frame_pos = frame_pos + 8'd1;
            end
            prev_raw = w.raw;
        end
        // an idle byte outside a frame leaves everything zero
        return r;
    endfunction

    // Driver: offer the next pending word, hold it until taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                plain_due.push_back(descramble_word(offered));
                words_in++;
                if (offered.start)
                    frames_in++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (raw_words.size() != 0 && !hold_send
                        && (no_gaps || $urandom_range(99) >= 22))
                begin
                    offered = raw_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= offered.raw;
                    s_axis_tuser  <= offered.start;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each word against the oldest prediction
    always @(posedge clk)
    begin : monitor
        plain_word_t due;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_out++;
            if (plain_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: tdata %04h tlast %0b tuser %0b",
                             m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
            else
            begin
                due = plain_due.pop_front();
                if (m_axis_tdata[7:0] !== due.plain || m_axis_tdata[15:8] !== due.index
                        || m_axis_tlast !== due.last || m_axis_tuser !== due.for_us)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch on word %0d: byte %02h/%02h index %0d/%0d",
                                  " last %0b/%0b us %0b/%0b (exp/act)"},
                                 words_out, due.plain, m_axis_tdata[7:0], due.index,
                                 m_axis_tdata[15:8], due.last, m_axis_tlast,
                                 due.for_us, m_axis_tuser);
                end
                if (due.for_us)
                    hits_seen++;
            end
        end
        m_axis_tready <= rst_n && (no_gaps || $urandom_range(99) >= 22);
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    // Scramble one frame of plain bytes; keep limits how many words go out
    task automatic push_frame(input int len, input bit aim, input int keep);
        byte_t plain [0:255];
        byte_t prev;
        byte_t key;
        byte_t raw;
        for (int i = 0; i < 256; i++)
            plain[i] = byte_t'($urandom);
        plain[0] = byte_t'(len);
        if (aim)
        begin
            for (int i = POS_ADDR_HI; i <= POS_ADDR_LO; i++)
                plain[i] = own_addr[(POS_ADDR_LO - i) * 8 +: 8];
            // spoil one address byte now and then
            if ($urandom_range(3) == 0)
                plain[$urandom_range(POS_ADDR_LO, POS_ADDR_HI)] ^= 8'h01 << $urandom_range(7);
        end
        key  = (len > POS_KEY) ? plain[POS_KEY] : 8'h00;
        prev = '0;
        for (int i = 0; i <= len && i < keep; i++)
        begin
            if (i == 0)
                raw = byte_t'(len);
            else if (i == len)
                raw = plain[i] ^ key;
            else if (i == POS_INVERT)
                raw = ~(plain[i] ^ SCRAMBLE_XOR);
            else
                raw = byte_t'(prev + CHAIN_ADD) ^ plain[i];
            prev = raw;
            raw_words.push_back('{raw: raw, start: (i == 0)});
            items_sent++;
        end
    endtask

    task automatic push_random(input int count);
        int goal;
        int len;
        int pick;
        goal = items_sent + count;
        while (items_sent < goal)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                // noise: stray bytes, rarely a bare start
                repeat ($urandom_range(3, 1))
                    raw_words.push_back('{raw: byte_t'($urandom),
                                          start: ($urandom_range(9) == 0)});
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    len = $urandom_range(7);
                else if (pick < 82)
                    len = $urandom_range(14, 8);
                else if (pick < 97)
                    len = $urandom_range(40, 15);
                else
                begin
                    len = $urandom_range(255, 41);
                    long_frames++;
                end
                push_frame(len, $urandom_range(99) < 75,
                           (len > 0 && $urandom_range(9) == 0) ? $urandom_range(len)
                                                                : FULL_FRAME);
            end
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (raw_words.size() != 0 || s_axis_tvalid || plain_due.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_addr(input logic [ADDR_W-1:0] a);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(posedge clk);
        cfg_we    <= 1'b0;
        own_addr  = a;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed frames
        write_addr(24'h5AC317);
        raw_words.push_back('{raw: 8'hFF, start: 1'b0});   // idle bytes before any frame
        raw_words.push_back('{raw: 8'h00, start: 1'b0});
        raw_words.push_back('{raw: 8'h00, start: 1'b1});   // zero length
        push_frame(1, 1'b0, FULL_FRAME);
        push_frame(2, 1'b0, FULL_FRAME);
        push_frame(6, 1'b0, 3);                            // dropped by the next start
        push_frame(10, 1'b1, FULL_FRAME);
        raw_words.push_back('{raw: 8'hFF, start: 1'b0});   // idle after a final byte
        drain();

        write_addr(24'hFFFFFF);
        push_random(390);
        drain();

        // Stretch with both sides always ready
        write_addr(24'h000000);
        no_gaps = 1'b1;
        push_random(390);
        drain();
        no_gaps = 1'b0;

        // Pause the sender halfway until the output has caught up
        write_addr(ADDR_W'($urandom));
        push_random(390);
        wait (raw_words.size() < 200);
        @(negedge clk);
        hold_send = 1'b1;
        do
            @(negedge clk);
        while (s_axis_tvalid || plain_due.size() != 0);
        hold_send = 1'b0;
        drain();

        write_addr(ADDR_W'($urandom));
        push_random(390);
        drain();

        $display("sent %0d words in %0d frames (%0d long), checked %0d results, %0d for us",
                 words_in, frames_in, long_frames, words_out, hits_seen);
        $display("addresses tried: directed, all ones, all zeros and two random values");
        if (mismatches == 0 && plain_due.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rfdaf_pkg.sv
rtl/core/radio_frame_descrambler_addr_filter_top.sv
tb/testbench.sv
